// File: rtl/fba_pkg.sv
// ----------------------------------------------------------------------------
// fba_pkg: shared types and constants of the frame bitmap allocator
// Holds the request and response payloads, the configuration register
// indexes, the controller states and the controller/datapath interface.
// ----------------------------------------------------------------------------
package fba_pkg;

  // Fixed field widths of the request, response and configuration port.
  localparam int FrameIdxW  = 8;
  localparam int FrameCntW  = 9;
  localparam int PageWordsW = 7;
  localparam int CfgIdxW    = 1;
  localparam int CfgDataW   = 9;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CFG_FRAME_COUNT = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_PAGE_WORDS  = 1'b1;

  typedef enum logic {
    REQ_ALLOC = 1'b0,
    REQ_FREE  = 1'b1
  } req_type_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_FRAME = 2'd1,
    ST_RANGE    = 2'd2
  } status_e;

  typedef struct packed {
    req_type_e             req_type;
    logic [FrameIdxW-1:0]  frame_index;
  } fba_req_t;

  typedef struct packed {
    logic [FrameIdxW-1:0]  granted_frame;
    status_e               status;
  } fba_rsp_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_CHECK,
    S_SCAN,
    S_ZERO
  } fba_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    clr_step;    // zero one page memory word during the reset sweep
    logic    load;        // capture a new request
    logic    scan_step;   // advance the allocate scan pointer
    logic    mark_used;   // set the used bit under the scan pointer
    logic    free_bit;    // clear the used bit of the requested frame
    logic    zero_load;   // load the page base address and word counter
    logic    zero_step;   // zero one page word and advance
    logic    result_en;   // register a response and raise the strobe
    logic    grant;       // response carries the scan pointer as frame
    status_e result_status;
  } fba_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_free_req;
    logic clr_last;
    logic no_frames;
    logic range_err;
    logic scan_free;
    logic scan_last;
    logic no_words;
    logic zero_last;
  } fba_stat_t;

endpackage

// File: rtl/fba_ctrl.sv
// ----------------------------------------------------------------------------
// fba_ctrl: request sequencer of the frame bitmap allocator
// Runs the reset sweep of the page memory, then takes requests and steps
// the datapath through the allocate scan or the page zeroing of a free.
// ----------------------------------------------------------------------------
module fba_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  fba_pkg::fba_stat_t stat_i,
  output fba_pkg::fba_cmd_t  cmd_o
);
  import fba_pkg::*;

  fba_state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.result_status = ST_OK;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (stat_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = S_CHECK;
        end
      end
      S_CHECK: begin
        if (!stat_i.is_free_req) begin
          if (stat_i.no_frames) begin
            cmd_o.result_en     = 1'b1;
            cmd_o.result_status = ST_NO_FRAME;
            state_d             = S_IDLE;
          end else begin
            state_d = S_SCAN;
          end
        end else if (stat_i.range_err) begin
          cmd_o.result_en     = 1'b1;
          cmd_o.result_status = ST_RANGE;
          state_d             = S_IDLE;
        end else begin
          cmd_o.free_bit  = 1'b1;
          cmd_o.zero_load = 1'b1;
          if (stat_i.no_words) begin
            cmd_o.result_en = 1'b1;
            state_d         = S_IDLE;
          end else begin
            state_d = S_ZERO;
          end
        end
      end
      S_SCAN: begin
        if (stat_i.scan_free) begin
          cmd_o.mark_used = 1'b1;
          cmd_o.result_en = 1'b1;
          cmd_o.grant     = 1'b1;
          state_d         = S_IDLE;
        end else if (stat_i.scan_last) begin
          cmd_o.result_en     = 1'b1;
          cmd_o.result_status = ST_NO_FRAME;
          state_d             = S_IDLE;
        end else begin
          cmd_o.scan_step = 1'b1;
        end
      end
      S_ZERO: begin
        cmd_o.zero_step = 1'b1;
        if (stat_i.zero_last) begin
          cmd_o.result_en = 1'b1;
          state_d         = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign busy = (state_q != S_IDLE);

endmodule

// File: rtl/fba_datapath.sv
// ----------------------------------------------------------------------------
// fba_datapath: bitmap, page memory and counters of the frame allocator
// Holds the configuration registers, the used-bit map, the scan pointer,
// the page word address and counter, the page memory and the response.
// The used-bit map is a memory with a registered read port; the reset sweep
// of the page memory clears it on the way.
// ----------------------------------------------------------------------------
module fba_datapath #(
  parameter int MAX_FRAMES     = 256,
  parameter int MAX_PAGE_WORDS = 64,
  parameter int WORD_BITS      = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  fba_pkg::fba_req_t              req_i,
  input  logic                           cfg_we_i,
  input  logic [fba_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [fba_pkg::CfgDataW-1:0]   cfg_wdata_i,
  input  fba_pkg::fba_cmd_t              cmd_i,
  output fba_pkg::fba_stat_t             stat_o,
  output logic                           done_o,
  output fba_pkg::fba_rsp_t              rsp_o
);
  import fba_pkg::*;

  localparam int FIdxW    = $clog2(MAX_FRAMES);
  localparam int CmpW     = (FIdxW + 1 > FrameCntW) ? FIdxW + 1 : FrameCntW;
  localparam int WCntW    = ($clog2(MAX_PAGE_WORDS + 1) > PageWordsW)
                            ? $clog2(MAX_PAGE_WORDS + 1) : PageWordsW;
  localparam int MemDepth = MAX_FRAMES * MAX_PAGE_WORDS;
  localparam int AddrW    = $clog2(MemDepth);
  localparam int ProdW    = FrameIdxW + WCntW;
  localparam int SweepW   = AddrW + 1;

  logic [FrameCntW-1:0]  frame_count_q;
  logic [PageWordsW-1:0] page_words_q;
  logic                  used_mem [MAX_FRAMES];
  logic                  used_rd_q;
  logic [FIdxW-1:0]      scan_q, scan_d;
  fba_req_t              req_q;
  logic [AddrW-1:0]      addr_q, addr_d;
  logic [WCntW-1:0]      wcnt_q;
  logic                  done_q;
  fba_rsp_t              rsp_q;
  logic [WORD_BITS-1:0]  page_mem [MemDepth];

  logic [CmpW-1:0]       eff_frames;
  logic [WCntW-1:0]      eff_words;
  logic [FIdxW-1:0]      free_idx;
  logic [ProdW-1:0]      base_prod;
  logic                  mem_we;
  logic                  map_we;
  logic [FIdxW-1:0]      map_addr;
  logic                  map_wdata;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_count_q <= FrameCntW'(256);
      page_words_q  <= PageWordsW'(64);
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_FRAME_COUNT) begin
        frame_count_q <= cfg_wdata_i;
      end else if (cfg_idx_i == CFG_PAGE_WORDS) begin
        page_words_q <= cfg_wdata_i[PageWordsW-1:0];
      end
    end
  end

  // Effective frame count and page size, limited to the storage provided.
  always_comb begin
    if (CmpW'(frame_count_q) > CmpW'(MAX_FRAMES)) begin
      eff_frames = CmpW'(MAX_FRAMES);
    end else begin
      eff_frames = CmpW'(frame_count_q);
    end
    if (WCntW'(page_words_q) > WCntW'(MAX_PAGE_WORDS)) begin
      eff_words = WCntW'(MAX_PAGE_WORDS);
    end else begin
      eff_words = WCntW'(page_words_q);
    end
  end

  assign free_idx  = FIdxW'(req_q.frame_index);
  assign base_prod = ProdW'(req_q.frame_index) * ProdW'(eff_words);

  // Captured request.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= req_i;
    end
  end

  // Allocate scan pointer, one frame per cycle from frame zero.
  always_comb begin
    scan_d = scan_q;
    if (cmd_i.load) begin
      scan_d = '0;
    end else if (cmd_i.scan_step) begin
      scan_d = scan_q + FIdxW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q <= '0;
    end else begin
      scan_q <= scan_d;
    end
  end

  // Used-bit map write port: cleared by the reset sweep, set by a grant and
  // cleared by a free.
  always_comb begin
    map_we    = 1'b0;
    map_addr  = free_idx;
    map_wdata = 1'b0;
    if (cmd_i.clr_step) begin
      map_we   = ({1'b0, addr_q} < SweepW'(MAX_FRAMES));
      map_addr = FIdxW'(addr_q);
    end else if (cmd_i.mark_used) begin
      map_we    = 1'b1;
      map_addr  = scan_q;
      map_wdata = 1'b1;
    end else if (cmd_i.free_bit) begin
      map_we = 1'b1;
    end
  end

  // The read follows the next scan pointer, so the registered bit always
  // belongs to the frame under the current scan pointer.
  always_ff @(posedge clk_i) begin
    if (map_we) begin
      used_mem[map_addr] <= map_wdata;
    end
    used_rd_q <= used_mem[scan_d];
  end

  // Page memory address: reset sweep, then the base of the freed page.
  always_comb begin
    addr_d = addr_q;
    if (cmd_i.zero_load) begin
      addr_d = AddrW'(base_prod);
    end else if (cmd_i.clr_step || cmd_i.zero_step) begin
      addr_d = addr_q + AddrW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q <= '0;
      wcnt_q <= '0;
    end else begin
      addr_q <= addr_d;
      if (cmd_i.zero_load) begin
        wcnt_q <= '0;
      end else if (cmd_i.zero_step) begin
        wcnt_q <= wcnt_q + WCntW'(1);
      end
    end
  end

  // Page memory: only ever written with zeros, one word per cycle.
  assign mem_we = cmd_i.clr_step || cmd_i.zero_step;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      page_mem[addr_q] <= '0;
    end
  end

  // Status toward the controller.
  always_comb begin
    stat_o.is_free_req = (req_q.req_type == REQ_FREE);
    stat_o.clr_last    = (addr_q == AddrW'(MemDepth - 1));
    stat_o.no_frames   = (eff_frames == '0);
    stat_o.range_err   = (CmpW'(req_q.frame_index) >= eff_frames);
    stat_o.scan_free   = !used_rd_q;
    stat_o.scan_last   = ((CmpW'(scan_q) + CmpW'(1)) == eff_frames);
    stat_o.no_words    = (eff_words == '0);
    stat_o.zero_last   = ((wcnt_q + WCntW'(1)) == eff_words);
  end

  // Response register and strobe.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= cmd_i.result_en;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.result_en) begin
      rsp_q.status        <= cmd_i.result_status;
      rsp_q.granted_frame <= cmd_i.grant ? FrameIdxW'(scan_q) : '0;
    end
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

// File: rtl/frame_bitmap_allocator.sv
// ----------------------------------------------------------------------------
// frame_bitmap_allocator: first-fit physical frame allocator
// Allocate takes the lowest free frame below the frame count; free clears a
// frame's used bit and zeroes its page words in the page memory.
//
//   Channel   Signals                               Direction
//   request   start, busy, req_i                    in (start), out (busy)
//   response  done_o, rsp_o                         out, one-cycle strobe
//   config    cfg_we_i, cfg_idx_i, cfg_wdata_i      in, write only
//
// A request is taken when start is high and busy is low; one request is
// worked on at a time. Allocate scans the used-bit map one bit per cycle
// up to the frame count. Free zeroes its page words one at a time through
// the single page memory write port; an out-of-range frame is answered
// from the check state. After reset, busy stays high while the page memory
// is zeroed. The response strobe lasts one cycle and cannot be held off.
// ----------------------------------------------------------------------------
module frame_bitmap_allocator #(
  parameter int MAX_FRAMES     = 256,
  parameter int MAX_PAGE_WORDS = 64,
  parameter int WORD_BITS      = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  fba_pkg::fba_req_t             req_i,
  output logic                          done_o,
  output fba_pkg::fba_rsp_t             rsp_o,
  input  logic                          cfg_we_i,
  input  logic [fba_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [fba_pkg::CfgDataW-1:0]  cfg_wdata_i
);
  import fba_pkg::*;

  fba_cmd_t  cmd;
  fba_stat_t stat;

  // Request sequencer.
  fba_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  // Map, memory and counters.
  fba_datapath #(
    .MAX_FRAMES     (MAX_FRAMES),
    .MAX_PAGE_WORDS (MAX_PAGE_WORDS),
    .WORD_BITS      (WORD_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .done_o      (done_o),
    .rsp_o       (rsp_o)
  );

  // A response always closes a request that was in progress.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy))
    else $error("response strobe without a request in progress");

  // An accepted request keeps the block busy in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted request did not make the block busy");

  // Only a successful allocate reports a nonzero frame.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.status != ST_OK) |-> (rsp_o.granted_frame == '0))
    else $error("failed request reported a frame number");

  // No two responses in consecutive cycles: a response returns the controller to idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("two responses in consecutive cycles");

endmodule
